[rtl/dgma_pkg.sv]
// ----------------------------------------------------------------------------
// dgma_pkg
// shared sizes, codes and fixed point widths of the grid map accumulator
// ----------------------------------------------------------------------------
package dgma_pkg;

	localparam int NUM_TYPES     = 16;
	localparam int MAX_SLOTS     = 16;
	localparam int MAX_PROBES    = 64;
	localparam int TABLE_SAMPLES = 1024;
	localparam int R2_CUT        = 64;

	localparam int FUNC_W  = 2;
	localparam int TYPE_W  = 4;
	localparam int SLOT_W  = 4;
	localparam int SIDX_W  = 10;
	localparam int ENER_W  = 32;
	localparam int COORD_W = 22;
	localparam int VOX_W   = 6;
	localparam int MAP_W   = 48;
	localparam int CFG_IW  = 3;
	localparam int CFG_DW  = 22;
	localparam int SPC_W   = 14;
	localparam int CNT_W   = 7;
	localparam int NS_W    = 5;

	localparam int TYPE_AW = $clog2(NUM_TYPES);
	localparam int SAMP_W  = $clog2(TABLE_SAMPLES);
	localparam int PIDX_W  = $clog2(MAX_PROBES);
	localparam int MAP_AW  = 2 * PIDX_W;
	localparam int TAB_AW  = TYPE_AW + SAMP_W;

	localparam int CW      = 25;
	localparam int SQ_W    = 2 * CW;
	localparam int R2_W    = SQ_W + 2;
	localparam int KEEP_W  = $clog2(R2_CUT) + 21;
	localparam int PROD_W  = KEEP_W + NS_W;
	localparam int FRAC2   = 20;

	localparam logic [R2_W-1:0] R2_LIMIT = R2_W'(R2_CUT) << FRAC2;

	localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_ATOM  = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd3;

	localparam logic [CFG_IW-1:0] CFG_ORIGIN_X = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_SLICE_Z  = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_SPACING  = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_PROBES_X = 3'd4;
	localparam logic [CFG_IW-1:0] CFG_PROBES_Y = 3'd5;
	localparam logic [CFG_IW-1:0] CFG_SLOTS    = 3'd6;
	localparam logic [CFG_IW-1:0] CFG_SAMPLES  = 3'd7;

endpackage

[rtl/dgma_if.sv]
// ----------------------------------------------------------------------------
// dgma_if
// input and result channels of the grid map accumulator
// ----------------------------------------------------------------------------
interface dgma_in_if;
	logic                                 valid;
	logic                                 ready;
	logic        [dgma_pkg::FUNC_W-1:0]   func;
	logic        [dgma_pkg::TYPE_W-1:0]   receptor_type;
	logic        [dgma_pkg::SLOT_W-1:0]   ligand_slot;
	logic        [dgma_pkg::SIDX_W-1:0]   sample_index;
	logic signed [dgma_pkg::ENER_W-1:0]   energy_value;
	logic signed [dgma_pkg::COORD_W-1:0]  atom_x;
	logic signed [dgma_pkg::COORD_W-1:0]  atom_y;
	logic signed [dgma_pkg::COORD_W-1:0]  atom_z;
	logic        [dgma_pkg::VOX_W-1:0]    voxel_x;
	logic        [dgma_pkg::VOX_W-1:0]    voxel_y;

	modport source (output valid, func, receptor_type, ligand_slot, sample_index,
		energy_value, atom_x, atom_y, atom_z, voxel_x, voxel_y, input ready);
	modport sink (input valid, func, receptor_type, ligand_slot, sample_index,
		energy_value, atom_x, atom_y, atom_z, voxel_x, voxel_y, output ready);
endinterface

interface dgma_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [dgma_pkg::MAP_W-1:0]  map_value;
	logic                               saturated_flag;

	modport source (output valid, map_value, saturated_flag, input ready);
	modport sink (input valid, map_value, saturated_flag, output ready);
endinterface

[rtl/dgma_ram.sv]
// ----------------------------------------------------------------------------
// dgma_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module dgma_ram #(
	parameter int W = 32,
	parameter int D = 1024
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/docking_grid_map_accumulate_top.sv]
// ----------------------------------------------------------------------------
// docking_grid_map_accumulate_top
// energy table and per slot slice maps, one voxel per cycle for all slots
// ----------------------------------------------------------------------------
// loads and atoms that do not scan answer in the cycle after they are taken;
// a read passes the registered map read port; a clear zeroes every map word
// atom: probes_x * probes_y voxel scan, counts at most 64, then s1 to s4 drain
// one word in flight at a time; the result register frees the next word
// reset: a clear sweep zeroes the map banks before the first word
// ----------------------------------------------------------------------------
module docking_grid_map_accumulate_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [dgma_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [dgma_pkg::CFG_DW-1:0]   cfg_data,
	dgma_in_if.sink                       in,
	dgma_out_if.source                    out
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CLEAR = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_READ  = 3'd4;

	localparam int MS = dgma_pkg::MAX_SLOTS;
	localparam int CW = dgma_pkg::CW;

	// configuration
	logic signed [dgma_pkg::COORD_W-1:0] origin_x_q, origin_y_q, slice_z_q;
	logic [dgma_pkg::SPC_W-1:0]          spacing_q;
	logic [dgma_pkg::CNT_W-1:0]          probes_x_q, probes_y_q;
	logic [dgma_pkg::NS_W-1:0]           slots_q, samples_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			slice_z_q  <= '0;
			spacing_q  <= dgma_pkg::SPC_W'(384);
			probes_x_q <= dgma_pkg::CNT_W'(64);
			probes_y_q <= dgma_pkg::CNT_W'(64);
			slots_q    <= dgma_pkg::NS_W'(1);
			samples_q  <= dgma_pkg::NS_W'(16);
		end else if (cfg_we) begin
			unique case (cfg_index)
				dgma_pkg::CFG_ORIGIN_X: origin_x_q <= cfg_data;
				dgma_pkg::CFG_ORIGIN_Y: origin_y_q <= cfg_data;
				dgma_pkg::CFG_SLICE_Z:  slice_z_q  <= cfg_data;
				dgma_pkg::CFG_SPACING:  spacing_q  <= cfg_data[dgma_pkg::SPC_W-1:0];
				dgma_pkg::CFG_PROBES_X: probes_x_q <= cfg_data[dgma_pkg::CNT_W-1:0];
				dgma_pkg::CFG_PROBES_Y: probes_y_q <= cfg_data[dgma_pkg::CNT_W-1:0];
				dgma_pkg::CFG_SLOTS:    slots_q    <= cfg_data[dgma_pkg::NS_W-1:0];
				dgma_pkg::CFG_SAMPLES:  samples_q  <= cfg_data[dgma_pkg::NS_W-1:0];
				default: ;
			endcase
		end
	end

	// clamped counts
	logic [dgma_pkg::CNT_W-1:0] nx, ny;
	logic [dgma_pkg::NS_W:0]    ns;
	assign nx = (probes_x_q > dgma_pkg::CNT_W'(dgma_pkg::MAX_PROBES)) ?
		dgma_pkg::CNT_W'(dgma_pkg::MAX_PROBES) : probes_x_q;
	assign ny = (probes_y_q > dgma_pkg::CNT_W'(dgma_pkg::MAX_PROBES)) ?
		dgma_pkg::CNT_W'(dgma_pkg::MAX_PROBES) : probes_y_q;
	assign ns = ({1'b0, slots_q} > (dgma_pkg::NS_W+1)'(MS)) ?
		(dgma_pkg::NS_W+1)'(MS) : {1'b0, slots_q};

	// control
	logic [2:0]                        state_q;
	logic                              emit_q;
	logic [dgma_pkg::MAP_AW-1:0]       clr_q;
	logic [dgma_pkg::PIDX_W-1:0]       x_q, y_q;
	logic signed [CW-1:0]              px_q, py_q;
	logic signed [CW-1:0]              ax_q, ay_q, dz_q;
	logic [dgma_pkg::TYPE_AW-1:0]      type_q;
	logic [dgma_pkg::SLOT_W-1:0]       rslot_q;
	logic                              rok_q;
	logic                              sat_q;
	logic                              out_valid_q;
	logic signed [dgma_pkg::MAP_W-1:0] out_map_q;
	logic                              out_sat_q;

	logic acc;
	logic type_ok, load_ok, read_ok;
	logic x_last, y_last;
	assign in.ready = (state_q == ST_IDLE) && (!out_valid_q || out.ready);
	assign acc      = in.valid && in.ready;
	assign type_ok  = {1'b0, in.receptor_type} < (dgma_pkg::TYPE_W+1)'(dgma_pkg::NUM_TYPES);
	assign load_ok  = type_ok
		&& ({1'b0, in.ligand_slot} < (dgma_pkg::SLOT_W+1)'(MS))
		&& ({1'b0, in.sample_index} < (dgma_pkg::SIDX_W+1)'(dgma_pkg::TABLE_SAMPLES));
	assign read_ok  = ({1'b0, in.ligand_slot} < (dgma_pkg::SLOT_W+1)'(MS))
		&& ({1'b0, in.voxel_x} < (dgma_pkg::VOX_W+1)'(dgma_pkg::MAX_PROBES))
		&& ({1'b0, in.voxel_y} < (dgma_pkg::VOX_W+1)'(dgma_pkg::MAX_PROBES));
	assign x_last   = (dgma_pkg::CNT_W'(x_q) + 1'b1) == nx;
	assign y_last   = (dgma_pkg::CNT_W'(y_q) + 1'b1) == ny;

	// voxel pipeline
	logic                        v_s1, v_s2, v_s3, v_s4;
	logic [dgma_pkg::MAP_AW-1:0] vox_s1, vox_s2, vox_s3, vox_s4;
	logic signed [CW-1:0]        dx_s1, dy_s1, dz_s1;
	logic [dgma_pkg::SQ_W-1:0]   sx_s2, sy_s2, sz_s2;
	logic [dgma_pkg::R2_W-1:0]   r2_s3;
	logic                        hit_s4;
	logic                        scan_v;

	assign scan_v = (state_q == ST_SCAN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= scan_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		vox_s1 <= {y_q, x_q};
		dx_s1  <= px_q - ax_q;
		dy_s1  <= py_q - ay_q;
		dz_s1  <= dz_q;
		vox_s2 <= vox_s1;
		sx_s2  <= dgma_pkg::SQ_W'(dx_s1 * dx_s1);
		sy_s2  <= dgma_pkg::SQ_W'(dy_s1 * dy_s1);
		sz_s2  <= dgma_pkg::SQ_W'(dz_s1 * dz_s1);
		vox_s3 <= vox_s2;
		r2_s3  <= dgma_pkg::R2_W'(sx_s2) + dgma_pkg::R2_W'(sy_s2) + dgma_pkg::R2_W'(sz_s2);
		vox_s4 <= vox_s3;
		hit_s4 <= r2_s3 < dgma_pkg::R2_LIMIT;
	end

	// sample index from r2
	logic [dgma_pkg::PROD_W-1:0]        prod;
	logic [dgma_pkg::PROD_W-dgma_pkg::FRAC2-1:0] kraw;
	logic [dgma_pkg::SAMP_W-1:0]        k;
	assign prod = dgma_pkg::PROD_W'(r2_s3[dgma_pkg::KEEP_W-1:0]) * dgma_pkg::PROD_W'(samples_q);
	assign kraw = prod[dgma_pkg::PROD_W-1:dgma_pkg::FRAC2];
	assign k    = (kraw > (dgma_pkg::PROD_W-dgma_pkg::FRAC2)'(dgma_pkg::TABLE_SAMPLES-1)) ?
		dgma_pkg::SAMP_W'(dgma_pkg::TABLE_SAMPLES-1) : kraw[dgma_pkg::SAMP_W-1:0];

	// memories, one bank per slot
	logic [dgma_pkg::ENER_W-1:0] tab_rd [MS];
	logic [dgma_pkg::MAP_W-1:0]  map_rd [MS];
	logic [dgma_pkg::MAP_W-1:0]  map_wd [MS];
	logic [MS-1:0]               map_we;
	logic [MS-1:0]               sat_hit;
	logic [dgma_pkg::MAP_AW-1:0] map_wa, map_ra;

	assign map_ra = (state_q == ST_IDLE) ? {in.voxel_y, in.voxel_x} : vox_s3;
	assign map_wa = (state_q == ST_CLEAR) ? clr_q : vox_s4;

	for (genvar s = 0; s < MS; s++) begin : g_bank
		logic signed [dgma_pkg::MAP_W:0] sum;
		logic                            tab_we;

		assign tab_we = acc && (in.func == dgma_pkg::FUNC_LOAD) && load_ok
			&& (in.ligand_slot == dgma_pkg::SLOT_W'(s));
		assign sum = $signed({map_rd[s][dgma_pkg::MAP_W-1], map_rd[s]})
			+ (dgma_pkg::MAP_W+1)'($signed(tab_rd[s]));

		always_comb begin
			sat_hit[s] = 1'b0;
			map_wd[s]  = sum[dgma_pkg::MAP_W-1:0];
			if (state_q == ST_CLEAR) begin
				map_wd[s] = '0;
			end else if (sum[dgma_pkg::MAP_W] != sum[dgma_pkg::MAP_W-1]) begin
				sat_hit[s] = map_we[s];
				map_wd[s]  = sum[dgma_pkg::MAP_W] ? {1'b1, {(dgma_pkg::MAP_W-1){1'b0}}}
					: {1'b0, {(dgma_pkg::MAP_W-1){1'b1}}};
			end
		end

		assign map_we[s] = (state_q == ST_CLEAR)
			|| (v_s4 && hit_s4 && ((dgma_pkg::NS_W+1)'(s) < ns));

		dgma_ram #(.W(dgma_pkg::ENER_W), .D(1 << dgma_pkg::TAB_AW)) u_tab (
			.clk   (clk),
			.we    (tab_we),
			.waddr ({in.receptor_type[dgma_pkg::TYPE_AW-1:0],
				in.sample_index[dgma_pkg::SAMP_W-1:0]}),
			.wdata (in.energy_value),
			.raddr ({type_q, k}),
			.rdata (tab_rd[s])
		);

		dgma_ram #(.W(dgma_pkg::MAP_W), .D(1 << dgma_pkg::MAP_AW)) u_map (
			.clk   (clk),
			.we    (map_we[s]),
			.waddr (map_wa),
			.wdata (map_wd[s]),
			.raddr (map_ra),
			.rdata (map_rd[s])
		);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			emit_q      <= 1'b0;
			clr_q       <= '0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out.ready) begin
				out_valid_q <= 1'b0;
			end
			if (|sat_hit) begin
				sat_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						unique case (in.func)
							dgma_pkg::FUNC_LOAD: begin
								out_valid_q <= 1'b1;
							end
							dgma_pkg::FUNC_CLEAR: begin
								state_q <= ST_CLEAR;
								emit_q  <= 1'b1;
								clr_q   <= '0;
							end
							dgma_pkg::FUNC_ATOM: begin
								if (type_ok && (nx != '0) && (ny != '0)) begin
									state_q <= ST_SCAN;
								end else begin
									out_valid_q <= 1'b1;
								end
							end
							dgma_pkg::FUNC_READ: begin
								state_q <= ST_READ;
							end
							default: ;
						endcase
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= ST_IDLE;
						if (emit_q) begin
							out_valid_q <= 1'b1;
						end
					end
				end
				ST_SCAN: begin
					if (x_last && y_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!(v_s1 || v_s2 || v_s3 || v_s4)) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
					end
				end
				ST_READ: begin
					state_q     <= ST_IDLE;
					out_valid_q <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (acc) begin
			x_q     <= '0;
			y_q     <= '0;
			px_q    <= CW'(origin_x_q);
			py_q    <= CW'(origin_y_q);
			ax_q    <= CW'(in.atom_x);
			ay_q    <= CW'(in.atom_y);
			dz_q    <= CW'(slice_z_q) - CW'(in.atom_z);
			type_q  <= in.receptor_type[dgma_pkg::TYPE_AW-1:0];
			rslot_q <= in.ligand_slot;
			rok_q   <= read_ok;
		end else if (scan_v) begin
			if (x_last) begin
				x_q  <= '0;
				px_q <= CW'(origin_x_q);
				y_q  <= y_q + 1'b1;
				py_q <= py_q + CW'(spacing_q);
			end else begin
				x_q  <= x_q + 1'b1;
				px_q <= px_q + CW'(spacing_q);
			end
		end
		if (acc && (in.func != dgma_pkg::FUNC_READ)) begin
			out_map_q <= '0;
		end else if (state_q == ST_READ) begin
			out_map_q <= rok_q ? map_rd[rslot_q] : '0;
		end
		out_sat_q <= sat_q || (|sat_hit);
	end

	assign out.valid          = out_valid_q;
	assign out.map_value      = out_map_q;
	assign out.saturated_flag = out_sat_q;

endmodule

[sim/tb_docking_grid_map_accumulate_top.sv]
// ----------------------------------------------------------------------------
// tb_docking_grid_map_accumulate_top
// checks table loads, map clears, atom accumulation, map reads and the sticky
// saturation flag against a built-in predictor, under several grid setups
// ----------------------------------------------------------------------------
module tb_docking_grid_map_accumulate_top;
	timeunit 1ns;
	timeprecision 1ps;

	import dgma_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam longint MAP_HI = 64'sh7FFF_FFFF_FFFF;
	localparam longint MAP_LO = -64'sh8000_0000_0000;

	typedef struct {
		logic [FUNC_W-1:0]         func;
		logic [TYPE_W-1:0]         receptor_type;
		logic [SLOT_W-1:0]         ligand_slot;
		logic [SIDX_W-1:0]         sample_index;
		logic signed [ENER_W-1:0]  energy_value;
		logic signed [COORD_W-1:0] atom_x;
		logic signed [COORD_W-1:0] atom_y;
		logic signed [COORD_W-1:0] atom_z;
		logic [VOX_W-1:0]          voxel_x;
		logic [VOX_W-1:0]          voxel_y;
	} grid_word_t;

	typedef struct {
		logic signed [MAP_W-1:0] map_value;
		logic                    saturated_flag;
	} map_result_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CFG_IW-1:0]   cfg_index;
	logic [CFG_DW-1:0]   cfg_data;

	dgma_in_if  in_ch();
	dgma_out_if out_ch();

	docking_grid_map_accumulate_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in        (in_ch),
		.out       (out_ch)
	);

	// grid setup as the block sees it
	longint grid_ox, grid_oy, grid_sz;
	int     grid_sp, grid_px, grid_py, grid_ns, grid_smp;

	logic signed [ENER_W-1:0] pair_energy [0:NUM_TYPES*MAX_SLOTS*TABLE_SAMPLES-1];
	bit                       pair_loaded [0:NUM_TYPES*MAX_SLOTS*TABLE_SAMPLES-1];
	longint                   slot_map [0:MAX_SLOTS*MAX_PROBES*MAX_PROBES-1];
	bit                       sat_seen;

	grid_word_t  pending_words[$];
	map_result_t expected_maps[$];
	grid_word_t  cur_word;

	int  errors, results_checked, idle_gap, hold_left, stall_cycles;
	int  func_count [4];
	bit  quiet, hold_done;

	always #5 clk = ~clk;

	function automatic int table_idx(int t, int s, int k);
		return (t * MAX_SLOTS + s) * TABLE_SAMPLES + k;
	endfunction

	// sample index of a probe, or -1 when it lies outside the cutoff
	function automatic int probe_sample(int ix, int iy, longint ax, longint ay, longint az);
		longint dx, dy, dz, r2, k;
		dx = grid_ox + longint'(grid_sp) * longint'(ix) - ax;
		dy = grid_oy + longint'(grid_sp) * longint'(iy) - ay;
		dz = grid_sz - az;
		r2 = dx * dx + dy * dy + dz * dz;
		if (r2 >= (longint'(R2_CUT) <<< 20))
			return -1;
		k = (r2 * longint'(grid_smp)) >>> 20;
		if (k > longint'(TABLE_SAMPLES - 1))
			return TABLE_SAMPLES - 1;
		return int'(k);
	endfunction

	function automatic map_result_t apply_grid_word(grid_word_t w);
		map_result_t r;
		int nx, ny, ns, k, m, t;
		longint sum;
		r.map_value = '0;
		t = int'(w.receptor_type);
		nx = (grid_px > MAX_PROBES) ? MAX_PROBES : grid_px;
		ny = (grid_py > MAX_PROBES) ? MAX_PROBES : grid_py;
		ns = (grid_ns > MAX_SLOTS) ? MAX_SLOTS : grid_ns;
		case (w.func)
			FUNC_LOAD: pair_energy[table_idx(t, int'(w.ligand_slot), int'(w.sample_index))]
				= w.energy_value;
			FUNC_CLEAR: foreach (slot_map[i]) slot_map[i] = 0;
			FUNC_ATOM: begin
				for (int y = 0; y < ny; y++)
					for (int x = 0; x < nx; x++) begin
						k = probe_sample(x, y, longint'(w.atom_x), longint'(w.atom_y),
							longint'(w.atom_z));
						if (k < 0)
							continue;
						for (int s = 0; s < ns; s++) begin
							m = (s * MAX_PROBES + y) * MAX_PROBES + x;
							sum = slot_map[m] + longint'(pair_energy[table_idx(t, s, k)]);
							if (sum > MAP_HI) begin
								sum = MAP_HI;
								sat_seen = 1;
							end
							if (sum < MAP_LO) begin
								sum = MAP_LO;
								sat_seen = 1;
							end
							slot_map[m] = sum;
						end
					end
			end
			default: begin
				m = (int'(w.ligand_slot) * MAX_PROBES + int'(w.voxel_y)) * MAX_PROBES
					+ int'(w.voxel_x);
				r.map_value = slot_map[m][MAP_W-1:0];
			end
		endcase
		r.saturated_flag = sat_seen;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [MAP_W-1:0] got, logic [MAP_W-1:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// ---- word driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				expected_maps.insert(expected_maps.size(), apply_grid_word(cur_word));
				func_count[cur_word.func]++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (idle_gap > 0) begin
					idle_gap--;
					in_ch.valid <= 1'b0;
				end else if (!quiet && $urandom_range(0, 7) == 0) begin
					idle_gap = int'($urandom_range(0, 2));
					in_ch.valid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					cur_word = pending_words.pop_front();
					in_ch.func          <= cur_word.func;
					in_ch.receptor_type <= cur_word.receptor_type;
					in_ch.ligand_slot   <= cur_word.ligand_slot;
					in_ch.sample_index  <= cur_word.sample_index;
					in_ch.energy_value  <= cur_word.energy_value;
					in_ch.atom_x        <= cur_word.atom_x;
					in_ch.atom_y        <= cur_word.atom_y;
					in_ch.atom_z        <= cur_word.atom_z;
					in_ch.voxel_x       <= cur_word.voxel_x;
					in_ch.voxel_y       <= cur_word.voxel_y;
					in_ch.valid         <= 1'b1;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ---- result monitor
	always @(posedge clk) begin
		map_result_t want;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_maps.size() == 0) begin
					report_mismatch("unexpected word", out_ch.map_value, '0);
				end else begin
					want = expected_maps.pop_front();
					if (out_ch.map_value !== want.map_value)
						report_mismatch("map_value", out_ch.map_value, want.map_value);
					if (out_ch.saturated_flag !== want.saturated_flag)
						report_mismatch("saturated_flag", MAP_W'(out_ch.saturated_flag),
							MAP_W'(want.saturated_flag));
				end
				results_checked++;
				if (results_checked == 20 && !hold_done) begin
					hold_done = 1;
					hold_left = 300;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				hold_left = int'($urandom_range(0, 2));
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// ---- watchdog
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout after %0d cycles without a word", STALL_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic wait_idle();
		while (pending_words.size() != 0 || expected_maps.size() != 0 || in_ch.valid)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_ORIGIN_X: grid_ox = longint'($signed(val));
			CFG_ORIGIN_Y: grid_oy = longint'($signed(val));
			CFG_SLICE_Z:  grid_sz = longint'($signed(val));
			CFG_SPACING:  grid_sp = int'(val[SPC_W-1:0]);
			CFG_PROBES_X: grid_px = int'(val[CNT_W-1:0]);
			CFG_PROBES_Y: grid_py = int'(val[CNT_W-1:0]);
			CFG_SLOTS:    grid_ns = int'(val[NS_W-1:0]);
			CFG_SAMPLES:  grid_smp = int'(val[NS_W-1:0]);
			default: ;
		endcase
	endtask

	task automatic setup_grid(int ox, int oy, int sz, int sp, int px, int py, int ns, int smp);
		wait_idle();
		set_reg(CFG_ORIGIN_X, CFG_DW'(ox));
		set_reg(CFG_ORIGIN_Y, CFG_DW'(oy));
		set_reg(CFG_SLICE_Z, CFG_DW'(sz));
		set_reg(CFG_SPACING, CFG_DW'(sp));
		set_reg(CFG_PROBES_X, CFG_DW'(px));
		set_reg(CFG_PROBES_Y, CFG_DW'(py));
		set_reg(CFG_SLOTS, CFG_DW'(ns));
		set_reg(CFG_SAMPLES, CFG_DW'(smp));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic grid_word_t blank_word(logic [FUNC_W-1:0] f);
		grid_word_t w;
		w = '{default: '0};
		w.func = f;
		w.receptor_type = TYPE_W'($urandom);
		w.ligand_slot   = SLOT_W'($urandom);
		w.sample_index  = SIDX_W'($urandom);
		w.energy_value  = ENER_W'($urandom);
		w.atom_x  = COORD_W'($urandom);
		w.atom_y  = COORD_W'($urandom);
		w.atom_z  = COORD_W'($urandom);
		w.voxel_x = VOX_W'($urandom);
		w.voxel_y = VOX_W'($urandom);
		return w;
	endfunction

	function automatic int rand_energy();
		if ($urandom_range(0, 3) == 0)
			return int'($urandom);
		return int'($urandom_range(0, 1 << 21)) - (1 << 20);
	endfunction

	task automatic push_load(int t, int s, int k, int e);
		grid_word_t w;
		w = blank_word(FUNC_LOAD);
		w.receptor_type = TYPE_W'(t);
		w.ligand_slot   = SLOT_W'(s);
		w.sample_index  = SIDX_W'(k);
		w.energy_value  = ENER_W'(e);
		pair_loaded[table_idx(t, s, k)] = 1;
		pending_words.insert(pending_words.size(), w);
	endtask

	task automatic push_read(int s, int vx, int vy);
		grid_word_t w;
		w = blank_word(FUNC_READ);
		w.ligand_slot = SLOT_W'(s);
		w.voxel_x = VOX_W'(vx);
		w.voxel_y = VOX_W'(vy);
		pending_words.insert(pending_words.size(), w);
	endtask

	task automatic push_clear();
		pending_words.insert(pending_words.size(), blank_word(FUNC_CLEAR));
	endtask

	// loads every not yet loaded table entry the atom will touch before sending it
	task automatic push_atom(int t, longint ax, longint ay, longint az);
		grid_word_t w;
		int nx, ny, ns, k;
		w = blank_word(FUNC_ATOM);
		w.receptor_type = TYPE_W'(t);
		w.atom_x = COORD_W'(ax);
		w.atom_y = COORD_W'(ay);
		w.atom_z = COORD_W'(az);
		nx = (grid_px > MAX_PROBES) ? MAX_PROBES : grid_px;
		ny = (grid_py > MAX_PROBES) ? MAX_PROBES : grid_py;
		ns = (grid_ns > MAX_SLOTS) ? MAX_SLOTS : grid_ns;
		for (int y = 0; y < ny; y++)
			for (int x = 0; x < nx; x++) begin
				k = probe_sample(x, y, longint'(w.atom_x), longint'(w.atom_y),
					longint'(w.atom_z));
				if (k >= 0)
					for (int s = 0; s < ns; s++)
						if (!pair_loaded[table_idx(t, s, k)])
							push_load(t, s, k, rand_energy());
			end
		pending_words.insert(pending_words.size(), w);
	endtask

	function automatic longint clamp_coord(longint v);
		if (v > 2097151)
			return 2097151;
		if (v < -2097152)
			return -2097152;
		return v;
	endfunction

	function automatic longint urand(int lo, int hi);
		return longint'($urandom_range(lo, hi));
	endfunction

	task automatic random_words(int count, int t_a, int t_b);
		int pick, nx, ny, ns;
		nx = (grid_px > MAX_PROBES) ? MAX_PROBES : ((grid_px == 0) ? 1 : grid_px);
		ny = (grid_py > MAX_PROBES) ? MAX_PROBES : ((grid_py == 0) ? 1 : grid_py);
		ns = (grid_ns > MAX_SLOTS) ? MAX_SLOTS : ((grid_ns == 0) ? 1 : grid_ns);
		repeat (count) begin
			pick = int'($urandom_range(0, 99));
			if (pick < 50) begin
				if ($urandom_range(0, 5) == 0)
					push_atom($urandom_range(0, 1) ? t_a : t_b,
						longint'($signed(COORD_W'($urandom))),
						longint'($signed(COORD_W'($urandom))),
						longint'($signed(COORD_W'($urandom))));
				else
					push_atom($urandom_range(0, 1) ? t_a : t_b,
						clamp_coord(grid_ox + longint'(grid_sp) * urand(0, nx - 1)
							+ urand(0, 8192) - 4096),
						clamp_coord(grid_oy + longint'(grid_sp) * urand(0, ny - 1)
							+ urand(0, 8192) - 4096),
						clamp_coord(grid_sz + urand(0, 6000) - 3000));
			end else if (pick < 82) begin
				if ($urandom_range(0, 3) == 0)
					push_read(int'($urandom_range(0, 15)), int'($urandom_range(0, 63)),
						int'($urandom_range(0, 63)));
				else
					push_read(int'($urandom_range(0, ns - 1)), int'($urandom_range(0, nx - 1)),
						int'($urandom_range(0, ny - 1)));
			end else if (pick < 97) begin
				push_load(int'($urandom_range(0, 15)), int'($urandom_range(0, 15)),
					int'($urandom_range(0, 1023)), rand_energy());
			end else begin
				push_clear();
			end
		end
	endtask

	initial begin
		clk = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 0;
		in_ch.func = '0;
		in_ch.receptor_type = '0;
		in_ch.ligand_slot = '0;
		in_ch.sample_index = '0;
		in_ch.energy_value = '0;
		in_ch.atom_x = '0;
		in_ch.atom_y = '0;
		in_ch.atom_z = '0;
		in_ch.voxel_x = '0;
		in_ch.voxel_y = '0;
		out_ch.ready = 0;
		grid_ox = 0;
		grid_oy = 0;
		grid_sz = 0;
		grid_sp = 384;
		grid_px = 64;
		grid_py = 64;
		grid_ns = 1;
		grid_smp = 16;
		foreach (pair_energy[i]) begin
			pair_energy[i] = '0;
			pair_loaded[i] = 0;
		end
		foreach (slot_map[i]) slot_map[i] = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed words at reset setup
		push_load(15, 15, 1023, 32'sh7FFF_FFFF);
		push_load(0, 0, 0, 32'sh8000_0000);
		push_read(15, 63, 63);
		push_read(0, 0, 0);
		push_atom(15, 0, 0, -8090);
		push_atom(3, 2097151, 2097151, 2097151);
		push_atom(3, -2097152, -2097152, -2097152);
		// atom just past the upper grid corner
		push_atom(3, 25192, 25192, -7800);
		push_read(0, 0, 0);
		push_read(0, 1, 2);
		push_read(0, 63, 63);
		push_clear();
		push_read(0, 0, 0);
		push_atom(0, 3 * 384, 2 * 384, -8000);
		push_read(0, 3, 2);

		setup_grid(0, 0, 0, 1024, 8, 8, 4, 0);
		random_words(8, 1, 2);
		setup_grid(-2097152, 2097151 - 8 * 512, -2097152, 512, 8, 8, 16, 0);
		random_words(6, 4, 4);
		setup_grid(2097151, -2097152, 2097151, 1, 64, 1, 2, 1);
		random_words(6, 6, 7);
		setup_grid(1000, -1000, 50, 8192, 64, 64, 1, 1);
		random_words(4, 8, 9);
		// counts past the limits and zero spacing and samples
		setup_grid(0, 0, 0, 0, 127, 2, 31, 0);
		random_words(5, 10, 10);
		setup_grid(0, 0, 0, 300, 0, 5, 0, 3);
		random_words(4, 12, 13);
		setup_grid(-5000, 7000, -300, 300, 12, 10, 3, 0);
		random_words(8, 1, 14);

		// back to back tail with no idling
		wait_idle();
		quiet = 1;
		random_words(6, 1, 14);

		wait_idle();
		repeat (20) @(posedge clk);
		$display("covered %0d loads, %0d clears, %0d atoms, %0d reads over 8 grid setups",
			func_count[FUNC_LOAD], func_count[FUNC_CLEAR], func_count[FUNC_ATOM],
			func_count[FUNC_READ]);
		$display("%0d result words checked, %0d mismatches", results_checked, errors);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

[sim.f]
rtl/dgma_pkg.sv
rtl/dgma_if.sv
rtl/dgma_ram.sv
rtl/docking_grid_map_accumulate_top.sv
sim/tb_docking_grid_map_accumulate_top.sv
